[design/lmfp_pkg.sv]
// Shared types and constants for the LED matrix frame packer.
package lmfp_pkg;

  localparam logic [7:0] MAX_LEVEL    = 8'd2;
  localparam int         COLUMNS      = 21;
  localparam int         ROWS         = 7;
  localparam int         STORE_DEPTH  = 24;
  localparam int         IDX_W        = $clog2(STORE_DEPTH);
  localparam int         FRAME_BYTES  = 32;
  localparam int         POS_W        = $clog2(FRAME_BYTES);
  localparam int         CMDQ_DEPTH   = 2;
  localparam logic [7:0] BYTE_DARK    = 8'hff;
  localparam logic [7:0] BYTE_LIT     = 8'hff;
  localparam logic [7:0] BYTE_OFF     = 8'h00;
  localparam logic [2:0] BIT_MASK     = 3'h7;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_IMAGE = 2'd1,
    OP_EMIT  = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_DARK,
    CMD_EMIT,
    CMD_READ
  } cmd_e;

  typedef enum logic {
    BK_CMD,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    cmd_e             kind;
    logic [IDX_W-1:0] idx;
    logic [2:0]       bit_sel;
    logic             hit;
  } cmd_t;

endpackage

[design/lmfp_front.sv]
// Front end: accepts commands, checks the position and maps it to a store byte and bit.
module lmfp_front (
  input  logic [1:0]      opcode_i,
  input  logic [4:0]      col_x_i,
  input  logic [2:0]      row_y_i,
  input  logic [7:0]      pixel_value_i,
  input  logic            accept_i,
  output logic            enq_o,
  output lmfp_pkg::cmd_t  cmd_o
);
  import lmfp_pkg::*;

  logic             in_range;
  logic [IDX_W-1:0] idx;
  opcode_e          op;

  assign op       = opcode_e'(opcode_i);
  assign in_range = (32'(col_x_i) < COLUMNS) && (32'(row_y_i) < ROWS) && (col_x_i < 5'd24);
  assign idx      = IDX_W'(5'(row_y_i[2:1]) * 5'd6 + (row_y_i[0] ? 5'd3 : 5'd0) + 5'd2
                    - 5'(col_x_i[4:3]));

  always_comb begin
    cmd_o.idx     = idx;
    cmd_o.bit_sel = col_x_i[2:0] & BIT_MASK;
    cmd_o.hit     = in_range;
    cmd_o.kind    = CMD_READ;
    enq_o         = 1'b0;
    unique case (op)
      OP_PIXEL: begin
        cmd_o.kind = (pixel_value_i == 8'd1) ? CMD_LIT : CMD_DARK;
        enq_o      = accept_i && in_range && (pixel_value_i[7:1] == 7'd0);
      end
      OP_IMAGE: begin
        cmd_o.kind = pixel_value_i[7] ? CMD_LIT : CMD_DARK;
        enq_o      = accept_i && in_range;
      end
      OP_EMIT: begin
        cmd_o.kind = CMD_EMIT;
        enq_o      = accept_i;
      end
      OP_READ: begin
        cmd_o.kind = CMD_READ;
        enq_o      = accept_i;
      end
      default: begin
        enq_o = 1'b0;
      end
    endcase
  end

endmodule

[design/lmfp_cmd_fifo.sv]
// Short command queue between the front end and the back end.
module lmfp_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enq_i,
  input  lmfp_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            deq_i,
  output logic            avail_o,
  output lmfp_pkg::cmd_t  cmd_o
);
  import lmfp_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_enq, do_deq;

  assign full_o  = (count_q == CNT_W'(CMDQ_DEPTH));
  assign avail_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && avail_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_enq) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_deq) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_enq && !do_deq) begin
      count_d = count_q + 1'b1;
    end else if (do_deq && !do_enq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_enq) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[design/lmfp_back.sv]
// Back end: pixel store, brightness register, frame sequencer and result register.
module lmfp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_data_i,
  input  logic            avail_i,
  input  lmfp_pkg::cmd_t  cmd_i,
  output logic            deq_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o
);
  import lmfp_pkg::*;

  logic [7:0]       store_q [STORE_DEPTH];
  logic [1:0]       level_q;
  bk_state_e        state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_free;
  logic [IDX_W-1:0] rd_idx, emit_idx;
  logic [7:0]       rd_data, mask, bright;
  logic             store_we;
  logic [7:0]       store_wdata;

  assign out_free    = !out_valid_q || pop;
  assign empty       = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;
  assign emit_idx    = IDX_W'(5'(pos_q[4:3]) * 5'd6 + 5'(pos_q[2:0]) - 5'd2);
  assign rd_idx      = (state_q == BK_EMIT) ? emit_idx : cmd_i.idx;
  assign rd_data     = store_q[rd_idx];
  assign mask        = 8'd1 << cmd_i.bit_sel;
  assign bright      = ({6'd0, level_q} > MAX_LEVEL) ? 8'd0 : MAX_LEVEL - {6'd0, level_q};

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    deq_o       = 1'b0;
    store_we    = 1'b0;
    store_wdata = (cmd_i.kind == CMD_LIT) ? (rd_data & ~mask) : (rd_data | mask);
    out_valid_d = out_valid_q && !pop;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      BK_CMD: begin
        if (avail_i) begin
          unique case (cmd_i.kind)
            CMD_LIT, CMD_DARK: begin
              store_we = 1'b1;
              deq_o    = 1'b1;
            end
            CMD_EMIT: begin
              deq_o   = 1'b1;
              pos_d   = '0;
              state_d = BK_EMIT;
            end
            CMD_READ: begin
              if (out_free) begin
                deq_o       = 1'b1;
                out_valid_d = 1'b1;
                out_last_d  = 1'b1;
                out_byte_d  = (cmd_i.hit && !rd_data[cmd_i.bit_sel]) ? BYTE_LIT : BYTE_OFF;
              end
            end
            default: begin
              deq_o = 1'b0;
            end
          endcase
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = (pos_q == POS_W'(FRAME_BYTES - 1));
          unique case (pos_q[2:0])
            3'd0:    out_byte_d = bright;
            3'd1:    out_byte_d = {5'd0, pos_q[4:3], 1'b0};
            default: out_byte_d = rd_data;
          endcase
          pos_d = pos_q + 1'b1;
          if (pos_q == POS_W'(FRAME_BYTES - 1)) begin
            state_d = BK_CMD;
          end
        end
      end
      default: begin
        state_d = BK_CMD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CMD;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      level_q     <= 2'd0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        level_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= BYTE_DARK;
      end
    end else if (store_we) begin
      store_q[cmd_i.idx] <= store_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule

[design/led_matrix_frame_packer.sv]
// Top level of the LED matrix frame packer: front end, command queue and back end.
//
//   channel   direction  handshake               payload
//   command   in         push / full             opcode_i, col_x_i, row_y_i, pixel_value_i
//   result    out        empty / pop             out_byte_o, last_byte_o
//   config    in         cfg_valid_i/cfg_ready_o cfg_data_i (brightness level)
//
// A command is taken and queued in a two-entry queue. The back end handles a pixel
// write or read, and sends a frame at one byte per cycle while the result register
// is free, from its single store read port. After reset the store is all dark and no
// clearing pass is needed. A stalled result register holds back reads and frame
// bytes, while the queue keeps taking commands until it fills.
module led_matrix_frame_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] opcode_i,
  input  logic [4:0] col_x_i,
  input  logic [2:0] row_y_i,
  input  logic [7:0] pixel_value_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);
  import lmfp_pkg::*;

  logic accept, enq, deq, avail;
  cmd_t enq_cmd, head_cmd;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  lmfp_front u_front (
    .opcode_i      (opcode_i),
    .col_x_i       (col_x_i),
    .row_y_i       (row_y_i),
    .pixel_value_i (pixel_value_i),
    .accept_i      (accept),
    .enq_o         (enq),
    .cmd_o         (enq_cmd)
  );

  lmfp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .cmd_i   (enq_cmd),
    .full_o  (full),
    .deq_i   (deq),
    .avail_o (avail),
    .cmd_o   (head_cmd)
  );

  lmfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .avail_i     (avail),
    .cmd_i       (head_cmd),
    .deq_o       (deq),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule
